// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the calibrator RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/dpoc_pkg.sv =====
// Shared widths, constants and types for the pressure offset calibrator.
// Depends on nothing; imported by the pressure datapath and the top level.
package dpoc_pkg;

    localparam int COUNT_W  = 14;
    localparam int OFFSET_W = 21;
    localparam int GAIN_W   = 18;
    localparam int PRESS_W  = 24;
    localparam int SUM_W    = 40;
    localparam int TALLY_W  = 16;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 144;

    localparam logic [GAIN_W-1:0] GAIN_RESET  = 18'd68944;
    localparam logic [7:0]        STATUS_MASK = 8'hC0;

    // Running sum with its reading count.
    typedef struct packed {
        logic signed [SUM_W-1:0] total;
        logic [TALLY_W-1:0]      tally;
    } run_sum_t;

    // One result item; the last field sits in the lowest bits.
    typedef struct packed {
        logic [TALLY_W-1:0]       vspeed_count;
        logic signed [SUM_W-1:0]  vspeed_sum;
        logic [TALLY_W-1:0]       airspeed_count;
        logic signed [SUM_W-1:0]  airspeed_sum;
        logic                     status_error;
        logic                     is_calibrated;
        logic                     pressure_valid;
        logic signed [PRESS_W-1:0] pressure_q8;
    } result_t;

    // Optional clear, then a saturating add of one pressure and a count bump.
    function automatic run_sum_t run_sum_add(run_sum_t cur, logic clr, logic add,
                                             logic signed [PRESS_W-1:0] p);
        run_sum_t                res;
        logic signed [SUM_W:0]   wide;
        logic signed [SUM_W-1:0] base_total;
        logic [TALLY_W-1:0]      base_tally;
        base_total = clr ? '0 : cur.total;
        base_tally = clr ? '0 : cur.tally;
        wide = (SUM_W+1)'(base_total) + (SUM_W+1)'(p);
        res.total = base_total;
        res.tally = base_tally;
        if (add)
        begin
            if (wide[SUM_W] != wide[SUM_W-1])
                res.total = wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                        : {1'b0, {(SUM_W-1){1'b1}}};
            else
                res.total = wide[SUM_W-1:0];
            if (base_tally != '1)
                res.tally = base_tally + 1'b1;
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/diff_pressure_offset_calibrator_core.sv =====
// Top level of the differential pressure zero-offset calibrator.
// Depends on dpoc_pkg, dpoc_pressure and assert_macros.svh.
//
//   port group   dir  width  contents
//   s_*          in   24     one reading: status/count bytes and clear flags
//   m_*          out  144    pressure, flags, two running sums with counts
//   cfg_*        in   18     gain_q16 register write
//
// Each item passes through the input register and then the result register;
// one item per cycle is sustained while m_tready is high. The per-item path is
// the gain multiply and the 40-bit saturating sum update. A stalled result
// holds in the result register while the input register still takes one item.
// Reset clears calibration and sums and restores the default gain.
`include "assert_macros.svh"

module diff_pressure_offset_calibrator_core
    import dpoc_pkg::*;
#(
    parameter int SKIP_READINGS     = 128,
    parameter int AVG_READINGS_LOG2 = 7
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [GAIN_W-1:0]      cfg_wdata,   // gain_q16
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // high_byte, low_byte, clear_airspeed_sum, clear_vspeed_sum, zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // pressure_q8, pressure_valid, is_calibrated, status_error, airspeed_sum,
    // airspeed_count, vspeed_sum, vspeed_count, zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int CNT_W = 9;
    localparam logic [CNT_W-1:0] FINISH_CNT =
        CNT_W'(SKIP_READINGS + (1 << AVG_READINGS_LOG2));
    localparam logic [CNT_W-1:0] SKIP_CNT = CNT_W'(SKIP_READINGS);
    localparam int SH_L   = (AVG_READINGS_LOG2 <= 7) ? 7 - AVG_READINGS_LOG2 : 0;
    localparam int SH_R   = (AVG_READINGS_LOG2 > 7) ? AVG_READINGS_LOG2 - 7 : 0;
    localparam int OFF_XW = OFFSET_W + 8;
    localparam int PAD_W  = OUT_TDATA_W - $bits(result_t);

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_high_reg;
    logic [7:0] in_low_reg;
    logic       in_clr_air_reg;
    logic       in_clr_vs_reg;

    // Configuration and state
    logic [GAIN_W-1:0]          gain_reg;
    logic [CNT_W-1:0]           cal_cnt_reg;
    logic signed [OFFSET_W-1:0] cal_acc_reg;
    logic                       cal_done_reg;
    logic signed [OFFSET_W-1:0] offset_reg;
    run_sum_t                   air_reg;
    run_sum_t                   vs_reg;

    // Result register
    logic    out_valid_reg;
    result_t out_res_reg;

    logic                       advance;
    logic                       status_err;
    logic signed [COUNT_W-1:0]  count_q0;
    logic [CNT_W-1:0]           cal_cnt_next;
    logic                       cal_finish;
    logic                       cal_sum_en;
    logic signed [OFFSET_W:0]   acc_wide;
    logic signed [OFFSET_W-1:0] cal_acc_next;
    logic signed [OFF_XW-1:0]   off_wide;
    logic signed [OFFSET_W-1:0] offset_next;
    logic signed [PRESS_W-1:0]  pressure_q8;
    run_sum_t                   air_next;
    run_sum_t                   vs_next;
    result_t                    res_next;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_res_reg};

    // Unpack: subtracting mid-scale from a 14-bit count flips its top bit.
    assign status_err = (in_high_reg & STATUS_MASK) != 8'h00;
    assign count_q0   = $signed({~in_high_reg[5], in_high_reg[4:0], in_low_reg});

    // Calibration sequencing
    assign cal_cnt_next = cal_cnt_reg + 1'b1;
    assign cal_finish   = !cal_done_reg && (cal_cnt_next == FINISH_CNT);
    assign cal_sum_en   = !cal_done_reg && !cal_finish && (cal_cnt_next >= SKIP_CNT);
    assign acc_wide     = (OFFSET_W+1)'(cal_acc_reg) + (OFFSET_W+1)'(count_q0);
    assign off_wide     = (OFF_XW'(cal_acc_reg) <<< SH_L) >>> SH_R;

    always_comb
    begin
        if (acc_wide[OFFSET_W] != acc_wide[OFFSET_W-1])
            cal_acc_next = acc_wide[OFFSET_W] ? {1'b1, {(OFFSET_W-1){1'b0}}}
                                              : {1'b0, {(OFFSET_W-1){1'b1}}};
        else
            cal_acc_next = acc_wide[OFFSET_W-1:0];

        if (off_wide > OFF_XW'($signed({1'b0, {(OFFSET_W-1){1'b1}}})))
            offset_next = {1'b0, {(OFFSET_W-1){1'b1}}};
        else if (off_wide < OFF_XW'($signed({1'b1, {(OFFSET_W-1){1'b0}}})))
            offset_next = {1'b1, {(OFFSET_W-1){1'b0}}};
        else
            offset_next = off_wide[OFFSET_W-1:0];
    end

    dpoc_pressure u_pressure
    (
        .count_q0    (count_q0),
        .offset_q7   (offset_reg),
        .gain_q16    (gain_reg),
        .pressure_q8 (pressure_q8)
    );

    assign air_next = run_sum_add(air_reg, in_clr_air_reg, cal_done_reg, pressure_q8);
    assign vs_next  = run_sum_add(vs_reg, in_clr_vs_reg, cal_done_reg, pressure_q8);

    always_comb
    begin
        res_next.pressure_valid = !status_err && cal_done_reg;
        res_next.pressure_q8    = res_next.pressure_valid ? pressure_q8 : '0;
        res_next.is_calibrated  = cal_done_reg || (!status_err && cal_finish);
        res_next.status_error   = status_err;
        res_next.airspeed_sum   = status_err ? air_reg.total : air_next.total;
        res_next.airspeed_count = status_err ? air_reg.tally : air_next.tally;
        res_next.vspeed_sum     = status_err ? vs_reg.total : vs_next.total;
        res_next.vspeed_count   = status_err ? vs_reg.tally : vs_next.tally;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            gain_reg      <= GAIN_RESET;
            cal_cnt_reg   <= '0;
            cal_acc_reg   <= '0;
            cal_done_reg  <= 1'b0;
            offset_reg    <= '0;
            air_reg       <= '0;
            vs_reg        <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (cfg_we)
                gain_reg <= cfg_wdata;

            if (advance && !status_err)
            begin
                air_reg <= air_next;
                vs_reg  <= vs_next;
                if (!cal_done_reg)
                    cal_cnt_reg <= cal_cnt_next;
                if (cal_finish)
                begin
                    offset_reg   <= offset_next;
                    cal_done_reg <= 1'b1;
                end
                if (cal_sum_en)
                    cal_acc_reg <= cal_acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_high_reg    <= s_tdata[7:0];
            in_low_reg     <= s_tdata[15:8];
            in_clr_air_reg <= s_tdata[16];
            in_clr_vs_reg  <= s_tdata[17];
        end
        if (advance)
            out_res_reg <= res_next;
    end

    `ASSERT_NEXT(a_cal_sticky, clk, rst_n, cal_done_reg, cal_done_reg)
    `ASSERT_SAME(a_valid_needs_cal, clk, rst_n, out_valid_reg && out_res_reg.pressure_valid,
                 out_res_reg.is_calibrated && !out_res_reg.status_error)
    `ASSERT_SAME(a_idle_pressure_zero, clk, rst_n,
                 out_valid_reg && !out_res_reg.pressure_valid,
                 out_res_reg.pressure_q8 == '0)
    `ASSERT_NEXT(a_err_keeps_state, clk, rst_n, advance && status_err,
                 $stable(air_reg) && $stable(vs_reg) && $stable(cal_cnt_reg))
    `ASSERT_NEXT(a_input_held, clk, rst_n, in_valid_reg && !advance, in_valid_reg)

endmodule

// ===== rtl/core/dpoc_pressure.sv =====
// Offset correction, gain multiply and Q8 rounding of one signed count.
// Depends on dpoc_pkg for field widths.
module dpoc_pressure
    import dpoc_pkg::*;
(
    input  logic signed [COUNT_W-1:0]  count_q0,
    input  logic signed [OFFSET_W-1:0] offset_q7,
    input  logic [GAIN_W-1:0]          gain_q16,
    output logic signed [PRESS_W-1:0]  pressure_q8
);

    localparam int D_W    = OFFSET_W + 1;
    localparam int PROD_W = D_W + GAIN_W + 1;
    localparam int RND_W  = PROD_W + 1;
    localparam int SHR_W  = RND_W - 15;

    logic signed [D_W-1:0]    diff_q7;
    logic signed [GAIN_W:0]   gain_s;
    logic signed [PROD_W-1:0] prod_q23;
    logic signed [RND_W-1:0]  rnd_q23;
    logic signed [SHR_W-1:0]  shr_q8;

    assign diff_q7  = (D_W'(count_q0) <<< 7) - D_W'(offset_q7);
    assign gain_s   = $signed({1'b0, gain_q16});
    assign prod_q23 = PROD_W'(diff_q7) * PROD_W'(gain_s);

    // Round half up, then floor by the arithmetic shift.
    assign rnd_q23 = RND_W'(prod_q23) + RND_W'(16384);
    assign shr_q8  = SHR_W'(rnd_q23 >>> 15);

    always_comb
    begin
        if (shr_q8 > SHR_W'($signed({1'b0, {(PRESS_W-1){1'b1}}})))
            pressure_q8 = {1'b0, {(PRESS_W-1){1'b1}}};
        else if (shr_q8 < SHR_W'($signed({1'b1, {(PRESS_W-1){1'b0}}})))
            pressure_q8 = {1'b1, {(PRESS_W-1){1'b0}}};
        else
            pressure_q8 = shr_q8[PRESS_W-1:0];
    end

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for diff_pressure_offset_calibrator_core.
// Depends on dpoc_pkg for widths and the result layout. It predicts every
// result item from its own model of calibration, pressure and running sums.
module testbench;
    import dpoc_pkg::*;

    localparam int SKIP_READINGS     = 128;
    localparam int AVG_READINGS_LOG2 = 7;
    localparam int CAL_END           = SKIP_READINGS + (1 << AVG_READINGS_LOG2);
    localparam int RUN_LIMIT         = 3000000;
    localparam int RANDOM_PER_GAIN   = 90;
    localparam int SAT_READINGS      = 90;
    localparam int HOLD_AT_RESULT    = 350;
    localparam int HOLD_CYCLES       = 80;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [GAIN_W-1:0]      cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    diff_pressure_offset_calibrator_core #(
        .SKIP_READINGS     (SKIP_READINGS),
        .AVG_READINGS_LOG2 (AVG_READINGS_LOG2)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    // Model state: calibration progress, offset, gain and the two sums.
    logic [8:0]        warmup_cnt = '0;
    longint            zero_acc   = 0;
    logic              zero_ready = 1'b0;
    longint            zero_q7    = 0;
    logic [GAIN_W-1:0] gain_cur   = GAIN_RESET;
    longint            air_acc    = 0;
    int                air_n      = 0;
    longint            climb_acc  = 0;
    int                climb_n    = 0;

    logic [IN_TDATA_W-1:0] readings_q[$];
    result_t               predicted_q[$];
    result_t               got;
    result_t               want;
    logic                  in_taken   = 1'b0;
    int                    rx_seen    = 0;
    int                    mismatches = 0;
    int unsigned           cycles     = 0;

    function automatic longint clamp_signed(longint v, int bits);
        longint top;
        top = (longint'(1) <<< (bits - 1)) - 1;
        if (v > top)
            return top;
        if (v < -top - 1)
            return -top - 1;
        return v;
    endfunction

    function automatic result_t predict_reading(logic [7:0] hb, logic [7:0] lb,
                                                logic clr_air, logic clr_climb);
        result_t     r;
        logic [13:0] raw;
        longint      cnt;
        longint      d;
        longint      p;
        longint      pq;
        r = '0;
        if ((hb & STATUS_MASK) != 0)
            r.status_error = 1'b1;
        else
        begin
            raw = {hb[5:0], lb};
            cnt = longint'(raw) - 8192;
            if (clr_air)
            begin
                air_acc = 0;
                air_n   = 0;
            end
            if (clr_climb)
            begin
                climb_acc = 0;
                climb_n   = 0;
            end
            if (!zero_ready)
            begin
                warmup_cnt = warmup_cnt + 1'b1;
                if (warmup_cnt == CAL_END)
                begin
                    if (AVG_READINGS_LOG2 <= 7)
                        zero_q7 = clamp_signed(zero_acc <<< (7 - AVG_READINGS_LOG2), 21);
                    else
                        zero_q7 = clamp_signed(zero_acc >>> (AVG_READINGS_LOG2 - 7), 21);
                    zero_ready = 1'b1;
                end
                else if (warmup_cnt >= SKIP_READINGS)
                    zero_acc = clamp_signed(zero_acc + cnt, 21);
            end
            else
            begin
                d  = cnt * 128 - zero_q7;
                p  = d * longint'(gain_cur);
                pq = clamp_signed((p + 16384) >>> 15, 24);
                r.pressure_q8    = pq[PRESS_W-1:0];
                r.pressure_valid = 1'b1;
                air_acc   = clamp_signed(air_acc + pq, 40);
                climb_acc = clamp_signed(climb_acc + pq, 40);
                if (air_n < 65535)
                    air_n++;
                if (climb_n < 65535)
                    climb_n++;
            end
        end
        r.is_calibrated  = zero_ready;
        r.airspeed_sum   = air_acc[SUM_W-1:0];
        r.airspeed_count = air_n[TALLY_W-1:0];
        r.vspeed_sum     = climb_acc[SUM_W-1:0];
        r.vspeed_count   = climb_n[TALLY_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] seen, logic [63:0] wanted);
        mismatches++;
        if (mismatches <= 100)
            $display("mismatch at result %0d: %s got %h, wanted %h",
                     rx_seen, field, seen, wanted);
    endtask

    // Monitor: checks result items first, then predicts the item taken at this edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[$bits(result_t)-1:0];
                if (predicted_q.size() == 0)
                    report_mismatch("result with no pending reading", m_tdata[63:0], '0);
                else
                begin
                    want = predicted_q.pop_front();
                    if (got.pressure_q8 !== want.pressure_q8)
                        report_mismatch("pressure_q8", got.pressure_q8, want.pressure_q8);
                    if (got.pressure_valid !== want.pressure_valid)
                        report_mismatch("pressure_valid", got.pressure_valid,
                                        want.pressure_valid);
                    if (got.is_calibrated !== want.is_calibrated)
                        report_mismatch("is_calibrated", got.is_calibrated,
                                        want.is_calibrated);
                    if (got.status_error !== want.status_error)
                        report_mismatch("status_error", got.status_error, want.status_error);
                    if (got.airspeed_sum !== want.airspeed_sum)
                        report_mismatch("airspeed_sum", got.airspeed_sum, want.airspeed_sum);
                    if (got.airspeed_count !== want.airspeed_count)
                        report_mismatch("airspeed_count", got.airspeed_count,
                                        want.airspeed_count);
                    if (got.vspeed_sum !== want.vspeed_sum)
                        report_mismatch("vspeed_sum", got.vspeed_sum, want.vspeed_sum);
                    if (got.vspeed_count !== want.vspeed_count)
                        report_mismatch("vspeed_count", got.vspeed_count, want.vspeed_count);
                end
                rx_seen++;
            end
            if (s_tvalid && s_tready)
                predicted_q.push_back(predict_reading(s_tdata[7:0], s_tdata[15:8],
                                                      s_tdata[16], s_tdata[17]));
        end
    end

    // Driver: bursts of items with random gaps; a gap of zero merges bursts.
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge clk)
    begin
        if (rst_n && !(s_tvalid && !in_taken))
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (readings_q.size() != 0)
            begin
                s_tdata  <= readings_q.pop_front();
                s_tvalid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 60);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left--;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: changes stall mode now and then, and once holds off for a long stretch.
    int       rx_mode      = 0;
    int       rx_mode_left = 0;
    int       hold_left    = 0;
    logic     hold_done    = 1'b0;
    logic [1:0] rx_tick    = '0;

    always @(negedge clk)
    begin
        rx_tick = rx_tick + 1'b1;
        if (rx_mode_left == 0)
        begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(16, 200);
        end
        else
            rx_mode_left--;
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (!hold_done && rx_seen >= HOLD_AT_RESULT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 9) != 0);
                default: m_tready <= (rx_tick != 2'b11);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= RUN_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic queue_reading(logic [7:0] hb, logic [7:0] lb, logic ca, logic cv);
        readings_q.push_back({6'b0, cv, ca, lb, hb});
    endtask

    task automatic queue_count(logic [13:0] raw, logic ca, logic cv);
        queue_reading({2'b00, raw[13:8]}, raw[7:0], ca, cv);
    endtask

    task automatic queue_error_reading();
        queue_reading({2'($urandom_range(1, 3)), 6'($urandom_range(0, 63))},
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
    endtask

    task automatic queue_random_reading();
        int          kind;
        logic [13:0] raw;
        kind = $urandom_range(0, 19);
        if (kind < 2)
            queue_error_reading();
        else
        begin
            if (kind == 2)
                raw = 14'h3FFF;
            else if (kind == 3)
                raw = 14'h0000;
            else
                raw = 14'($urandom_range(0, 16383));
            queue_count(raw, $urandom_range(0, 29) == 0, $urandom_range(0, 29) == 0);
        end
    endtask

    // Waits until no item is queued, offered or outstanding.
    task automatic wait_drained();
        @(posedge clk);
        while (readings_q.size() != 0 || s_tvalid || predicted_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_gain(logic [GAIN_W-1:0] g);
        wait_drained();
        repeat (3) @(negedge clk);
        cfg_wdata <= g;
        cfg_we    <= 1'b1;
        gain_cur   = g;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        int                good;
        logic [13:0]       raw;
        logic [GAIN_W-1:0] gains[7];
        gains = '{18'h3FFFF, 18'd0, 18'd1, GAIN_RESET, 18'($urandom_range(0, 262143)),
                  18'($urandom_range(0, 262143)), 18'($urandom_range(60000, 80000))};

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        write_gain(GAIN_RESET);

        // Status errors while uncalibrated leave the warmup count alone; three good readings follow.
        queue_reading(8'hC0, 8'h00, 1'b1, 1'b1);
        queue_reading(8'h40, 8'hFF, 1'b0, 1'b1);
        queue_reading(8'h80, 8'h12, 1'b1, 1'b0);
        queue_reading(8'hFF, 8'hFF, 1'b1, 1'b1);
        queue_count(14'h3FFF, 1'b1, 1'b0);
        queue_count(14'h0000, 1'b0, 1'b1);
        queue_count(14'h2000, 1'b1, 1'b1);

        // Skip window, then the averaged window near a quarter scale below
        // mid-scale; the last good reading sets the offset and gives no pressure.
        good = 3;
        while (good < CAL_END)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_error_reading();
            else
            begin
                good++;
                if (good == SKIP_READINGS)
                    raw = 14'h3FFF;
                else if (good == CAL_END - 1)
                    raw = 14'h0000;
                else if (good > SKIP_READINGS && good < CAL_END)
                    raw = 14'(32'h1000 + $urandom_range(0, 127) - 64);
                else
                    raw = 14'($urandom_range(0, 16383));
                queue_count(raw, $urandom_range(0, 15) == 0, $urandom_range(0, 15) == 0);
            end
        end

        queue_count(14'h3FFF, 1'b0, 1'b0);
        queue_count(14'h0000, 1'b0, 1'b0);
        queue_count(14'h2000, 1'b0, 1'b0);
        queue_count(14'h1000, 1'b0, 1'b0);
        queue_reading(8'hC0, 8'h55, 1'b1, 1'b1);
        queue_reading(8'h7F, 8'hAA, 1'b1, 1'b0);
        queue_count(14'h2ABC, 1'b1, 1'b0);
        queue_count(14'h1543, 1'b0, 1'b1);
        queue_count(14'h3000, 1'b1, 1'b1);

        foreach (gains[i])
        begin
            write_gain(gains[i]);
            repeat (RANDOM_PER_GAIN) queue_random_reading();
        end

        // Full-scale readings at the largest gain add the largest pressures
        // to both sums, then each sum is cleared on its own.
        write_gain(18'h3FFFF);
        queue_count(14'h3FFF, 1'b1, 1'b1);
        repeat (SAT_READINGS) queue_count(14'h3FFF, 1'b0, 1'b0);
        queue_count(14'h3FFF, 1'b1, 1'b0);
        queue_count(14'h0000, 1'b0, 1'b1);
        repeat (20) queue_random_reading();

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule
